>>> rtl/bcpr_pkg.sv
// Shared types, constants and helpers for the BIO chunk precision/recall block.
`timescale 1ns / 1ps
`default_nettype none

package bcpr_pkg;

	localparam int NUM_TYPES  = 16;
	localparam int COUNT_BITS = 32;

	localparam int TYPE_W    = 4;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int OUT_CNT_W = 32;
	localparam int BP_W      = 14;
	localparam int BP_SCALE  = 10000;
	localparam int DIV_W     = COUNT_BITS + BP_W;
	localparam int STEP_W    = $clog2(BP_W);
	localparam int WIDE_W    = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

	typedef logic [KIND_W-1:0]     kind_t;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	localparam kind_t KIND_O = 2'd0;
	localparam kind_t KIND_B = 2'd1;
	localparam kind_t KIND_I = 2'd2;

	typedef struct packed {
		kind_t             gold_kind;
		logic [TYPE_W-1:0] gold_type;
		kind_t             guess_kind;
		logic [TYPE_W-1:0] guess_type;
		logic              sentence_end;
		logic              stream_end;
	} tok_t;

	typedef struct packed {
		logic                 is_overall;
		logic [TYPE_W-1:0]    ent_type;
		logic [OUT_CNT_W-1:0] true_positives;
		logic [OUT_CNT_W-1:0] guessed;
		logic [BP_W-1:0]      precision_bp;
		logic [BP_W-1:0]      recall_bp;
		logic                 last_record;
	} rec_t;

	typedef struct packed {
		cnt_t tp;
		cnt_t fp;
		cnt_t fn;
	} row_t;

	typedef enum logic [1:0] {
		EV_TP,
		EV_FP,
		EV_FN
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t          kind;
		logic [TYPE_W-1:0] etype;
	} ev_t;

	// Counters wider than the result field saturate to its maximum.
	function automatic logic [OUT_CNT_W-1:0] clamp_out(input cnt_t v);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(v);
		if (w > WIDE_W'({OUT_CNT_W{1'b1}})) begin
			return '1;
		end
		return w[OUT_CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> rtl/bio_chunk_precision_recall.sv
// Top level of the BIO chunk precision/recall counter and report engine.
//
// Usage: one token position per beat on the tok channel (gold and predicted tag,
// sentence end, stream end). Beats leave on the rpt channel as report records.
// Each chunk close is counted in three steps (row read, row update, total
// update); a token closes at most four chunks, and a true positive counts a
// gold and a guess close as one update. tok_stall stays high from the cycle
// after the token is taken until its last update is done, or on stream end
// until the overall record is taken. On stream end the block walks all
// types, and for each reported record does the multiply by 10000, runs the
// shared one-bit-a-step divider (precision, then recall) and loads the
// output register.
// A record waits in the output register while rpt_stall is high; the walk
// resumes after it is taken. The overall record ends the report and carries
// last_record; after it is taken all counters read as zero again.
// Reset clears the open-chunk state, the totals and the per-row valid bits,
// so the per-type counter memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bio_chunk_precision_recall
	import bcpr_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  tok_valid,
	output logic tok_stall,
	input  wire tok_t tok,
	output logic rpt_valid,
	input  wire  rpt_stall,
	output rec_t rpt
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EV_RD,
		S_EV_WR,
		S_EV_TOT,
		S_RP_RD,
		S_RP_CHK,
		S_MUL,
		S_DIV,
		S_OUT
	} state_t;

	state_t            state_q;
	logic              gold_open_q, guess_open_q, match_q;
	logic [TYPE_W-1:0] gold_type_q, guess_type_q;
	ev_t               ev_q [4];
	logic [3:0]        ev_pend_q;
	logic              rep_pend_q;
	ev_t               cur_ev_q;

	row_t              mem_q [NUM_TYPES];
	logic [NUM_TYPES-1:0] row_valid_q;
	row_t              rd_row_q;
	logic              rd_valid_q;

	cnt_t              tot_tp_q, tot_fp_q, tot_fn_q;
	logic [IDX_W-1:0]  idx_q;
	cnt_t              rep_tp_q, rep_fp_q, rep_fn_q;
	logic              rep_overall_q;
	logic [OUT_CNT_W-1:0] gsd_q;
	logic [DIV_W-1:0]  prod_q, num_q, dsh_q;
	logic [BP_W-1:0]   quo_q, prec_q;
	logic [STEP_W-1:0] step_q;
	logic              pass_q;
	logic              rpt_valid_q;
	rec_t              rpt_q;

	// Token decode: close, start and match decisions of one position.
	logic              accept;
	logic              gcont, qcont, g1, q1, tp1, fn1, fp1;
	logic              gopen_a, qopen_a, match_a;
	logic              gstart, qstart, gopen_b, qopen_b, match_b;
	logic [TYPE_W-1:0] gtype_b, qtype_b;
	logic              tok_end, g2, q2, tp2, fn2, fp2;
	ev_t               new_ev [4];
	logic [3:0]        new_pend;

	always_comb begin
		accept  = tok_valid && !tok_stall;
		gcont   = gold_open_q && tok.gold_kind == KIND_I && tok.gold_type == gold_type_q;
		qcont   = guess_open_q && tok.guess_kind == KIND_I && tok.guess_type == guess_type_q;
		g1      = gold_open_q && !gcont;
		q1      = guess_open_q && !qcont;
		tp1     = g1 && q1 && match_q;
		fn1     = g1 && !tp1;
		fp1     = q1 && !tp1;
		gopen_a = gold_open_q && !g1;
		qopen_a = guess_open_q && !q1;
		match_a = (g1 || q1) ? 1'b0 : match_q;
		gstart  = !gcont && tok.gold_kind == KIND_B;
		qstart  = !qcont && tok.guess_kind != KIND_O;
		gopen_b = gstart || gopen_a;
		qopen_b = qstart || qopen_a;
		gtype_b = gstart ? tok.gold_type : gold_type_q;
		qtype_b = qstart ? tok.guess_type : guess_type_q;
		if (gstart && qstart) begin
			match_b = tok.gold_type == tok.guess_type;
		end else if (gstart || qstart) begin
			match_b = 1'b0;
		end else begin
			match_b = match_a;
		end
		tok_end = tok.sentence_end || tok.stream_end;
		g2      = tok_end && gopen_b;
		q2      = tok_end && qopen_b;
		tp2     = g2 && q2 && match_b;
		fn2     = g2 && !tp2;
		fp2     = q2 && !tp2;

		new_ev[0] = '{kind: (tp1 ? EV_TP : EV_FN), etype: gold_type_q};
		new_ev[1] = '{kind: EV_FP, etype: guess_type_q};
		new_ev[2] = '{kind: (tp2 ? EV_TP : EV_FN), etype: gtype_b};
		new_ev[3] = '{kind: EV_FP, etype: qtype_b};
		new_pend  = {fp2, tp2 || fn2, fp1, tp1 || fn1};
	end

	// Lowest pending event goes first; the counts commute, so order is free.
	logic [1:0] sel;
	always_comb begin
		sel = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (ev_pend_q[i]) begin
				sel = 2'(i);
			end
		end
	end

	// Shared saturating incrementer for row fields and totals.
	row_t cur_row;
	cnt_t inc_in, inc_out;
	row_t wr_row;
	logic cur_in_range;

	always_comb begin
		cur_row      = rd_valid_q ? rd_row_q : '0;
		cur_in_range = 32'(cur_ev_q.etype) < NUM_TYPES;
		inc_in       = '0;
		unique case (state_q)
			S_EV_WR: begin
				case (cur_ev_q.kind)
					EV_TP:   inc_in = cur_row.tp;
					EV_FP:   inc_in = cur_row.fp;
					EV_FN:   inc_in = cur_row.fn;
					default: inc_in = '0;
				endcase
			end
			S_EV_TOT: begin
				case (cur_ev_q.kind)
					EV_TP:   inc_in = tot_tp_q;
					EV_FP:   inc_in = tot_fp_q;
					EV_FN:   inc_in = tot_fn_q;
					default: inc_in = '0;
				endcase
			end
			default: inc_in = '0;
		endcase
		inc_out = (&inc_in) ? inc_in : inc_in + COUNT_BITS'(1);
		wr_row  = cur_row;
		case (cur_ev_q.kind)
			EV_TP:   wr_row.tp = inc_out;
			EV_FP:   wr_row.fp = inc_out;
			EV_FN:   wr_row.fn = inc_out;
			default: wr_row    = cur_row;
		endcase
	end

	// Per-type counter memory: one write and one registered read per cycle.
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;

	always_comb begin
		mem_we    = state_q == S_EV_WR && cur_in_range;
		mem_waddr = IDX_W'(cur_ev_q.etype);
		mem_raddr = (state_q == S_EV_RD) ? IDX_W'(ev_q[sel].etype) : idx_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= wr_row;
		end
		rd_row_q   <= mem_q[mem_raddr];
		rd_valid_q <= row_valid_q[mem_raddr];
	end

	// Shared adder for the two denominators; the divider step has its own subtractor.
	logic [COUNT_BITS:0] add_sum;
	cnt_t                add_sat;
	logic [DIV_W-1:0]    den_sh;
	logic                div_ge;
	logic [DIV_W-1:0]    num_nxt;
	logic [BP_W-1:0]     quo_nxt;
	logic                rep_zero;
	row_t                chk_row;
	logic                last_idx;

	always_comb begin
		add_sum  = {1'b0, rep_tp_q} + {1'b0, (state_q == S_MUL) ? rep_fp_q : rep_fn_q};
		add_sat  = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
		den_sh   = DIV_W'(add_sum) << (BP_W - 1);
		div_ge   = num_q >= dsh_q;
		num_nxt  = div_ge ? num_q - dsh_q : num_q;
		quo_nxt  = {quo_q[BP_W-2:0], div_ge};
		rep_zero = rep_tp_q == '0;
		chk_row  = rd_valid_q ? rd_row_q : '0;
		last_idx = 32'(idx_q) == NUM_TYPES - 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			gold_open_q  <= 1'b0;
			gold_type_q  <= '0;
			guess_open_q <= 1'b0;
			guess_type_q <= '0;
			match_q      <= 1'b0;
			ev_pend_q    <= '0;
			rep_pend_q   <= 1'b0;
			row_valid_q  <= '0;
			tot_tp_q     <= '0;
			tot_fp_q     <= '0;
			tot_fn_q     <= '0;
			rpt_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						gold_open_q  <= tok_end ? 1'b0 : gopen_b;
						guess_open_q <= tok_end ? 1'b0 : qopen_b;
						gold_type_q  <= gtype_b;
						guess_type_q <= qtype_b;
						match_q      <= tok_end ? 1'b0 : match_b;
						ev_q         <= new_ev;
						ev_pend_q    <= new_pend;
						rep_pend_q   <= tok.stream_end;
						idx_q        <= '0;
						if (new_pend != '0) begin
							state_q <= S_EV_RD;
						end else if (tok.stream_end) begin
							state_q <= S_RP_RD;
						end
					end
				end
				S_EV_RD: begin
					cur_ev_q       <= ev_q[sel];
					ev_pend_q[sel] <= 1'b0;
					state_q        <= S_EV_WR;
				end
				S_EV_WR: begin
					if (cur_in_range) begin
						row_valid_q[mem_waddr] <= 1'b1;
					end
					state_q <= S_EV_TOT;
				end
				S_EV_TOT: begin
					case (cur_ev_q.kind)
						EV_TP:   tot_tp_q <= inc_out;
						EV_FP:   tot_fp_q <= inc_out;
						EV_FN:   tot_fn_q <= inc_out;
						default: tot_tp_q <= tot_tp_q;
					endcase
					if (ev_pend_q != '0) begin
						state_q <= S_EV_RD;
					end else if (rep_pend_q) begin
						state_q <= S_RP_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RP_RD: begin
					state_q <= S_RP_CHK;
				end
				S_RP_CHK: begin
					if (chk_row.tp != '0) begin
						rep_tp_q      <= chk_row.tp;
						rep_fp_q      <= chk_row.fp;
						rep_fn_q      <= chk_row.fn;
						rep_overall_q <= 1'b0;
						state_q       <= S_MUL;
					end else if (last_idx) begin
						rep_tp_q      <= tot_tp_q;
						rep_fp_q      <= tot_fp_q;
						rep_fn_q      <= tot_fn_q;
						rep_overall_q <= 1'b1;
						state_q       <= S_MUL;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RP_RD;
					end
				end
				S_MUL: begin
					prod_q  <= DIV_W'(rep_tp_q) * DIV_W'(BP_SCALE);
					num_q   <= DIV_W'(rep_tp_q) * DIV_W'(BP_SCALE);
					dsh_q   <= den_sh;
					gsd_q   <= clamp_out(add_sat);
					quo_q   <= '0;
					step_q  <= '0;
					pass_q  <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (32'(step_q) == BP_W - 1 && !pass_q) begin
						// Precision done; restart on the recall denominator.
						prec_q <= quo_nxt;
						pass_q <= 1'b1;
						num_q  <= prod_q;
						dsh_q  <= den_sh;
						quo_q  <= '0;
						step_q <= '0;
					end else begin
						num_q  <= num_nxt;
						dsh_q  <= dsh_q >> 1;
						quo_q  <= quo_nxt;
						step_q <= step_q + STEP_W'(1);
						if (32'(step_q) == BP_W - 1) begin
							rpt_q.is_overall     <= rep_overall_q;
							rpt_q.ent_type       <= rep_overall_q ? '0 : TYPE_W'(idx_q);
							rpt_q.true_positives <= clamp_out(rep_tp_q);
							rpt_q.guessed        <= gsd_q;
							rpt_q.precision_bp   <= rep_zero ? '0 : prec_q;
							rpt_q.recall_bp      <= rep_zero ? '0 : quo_nxt;
							rpt_q.last_record    <= rep_overall_q;
							rpt_valid_q          <= 1'b1;
							state_q              <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (!rpt_stall) begin
						rpt_valid_q <= 1'b0;
						if (rep_overall_q) begin
							row_valid_q <= '0;
							tot_tp_q    <= '0;
							tot_fp_q    <= '0;
							tot_fn_q    <= '0;
							rep_pend_q  <= 1'b0;
							state_q     <= S_IDLE;
						end else if (last_idx) begin
							rep_tp_q      <= tot_tp_q;
							rep_fp_q      <= tot_fp_q;
							rep_fn_q      <= tot_fn_q;
							rep_overall_q <= 1'b1;
							state_q       <= S_MUL;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RP_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tok_stall = state_q != S_IDLE;
	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

	// A record is only presented from the output state.
	a_rpt_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> state_q == S_OUT)
		else $error("record presented outside the output state");

	// Only the overall record ends the report.
	a_last_overall: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> rpt.last_record == rpt.is_overall)
		else $error("last_record does not match is_overall");

	a_bp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> (rpt.precision_bp <= BP_W'(BP_SCALE))
			&& (rpt.recall_bp <= BP_W'(BP_SCALE)))
		else $error("ratio above 100 percent");

	// No new token may arrive while counter updates are still queued.
	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_stall |-> ev_pend_q == '0 && !rep_pend_q)
		else $error("token accepted with pending updates");

	// Taking the overall record clears all counts.
	a_clear_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && !rpt_stall && rpt.is_overall) |=>
			row_valid_q == '0 && tot_tp_q == '0 && tot_fp_q == '0 && tot_fn_q == '0)
		else $error("counters not cleared after the report");

endmodule

`default_nettype wire

>>> verif/bio_chunk_precision_recall_tb.sv
// Self-checking testbench for the BIO chunk precision/recall block.
`timescale 1ns / 1ps

module bio_chunk_precision_recall_tb;
	import bcpr_pkg::*;

	localparam kind_t KIND_OTHER = 2'd3;
	localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam int MAX_WAIT = 18;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tok_valid = 1'b0;
	logic tok_stall;
	tok_t tok = '0;
	logic rpt_valid;
	logic rpt_stall = 1'b0;
	rec_t rpt;

	bio_chunk_precision_recall dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok      (tok),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt      (rpt)
	);

	// Chunk tracking and counters of the scoring model.
	bit              gold_open;
	logic [3:0]      gold_open_type;
	bit              guess_open;
	logic [3:0]      guess_open_type;
	bit              chunks_agree;
	longint unsigned tp_by_type[NUM_TYPES];
	longint unsigned fp_by_type[NUM_TYPES];
	longint unsigned fn_by_type[NUM_TYPES];
	longint unsigned tp_total, fp_total, fn_total;

	rec_t expected_recs[$];
	bit   no_gaps = 1'b0;
	int   mismatches = 0;
	int   tokens_sent = 0;
	int   records_seen = 0;
	int   reports_seen = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("bio_chunk_precision_recall_tb: FAIL");
		$finish;
	end

	function automatic longint unsigned sat_inc(input longint unsigned c);
		return (c < CNT_MAX) ? c + 64'd1 : c;
	endfunction

	function automatic logic [BP_W-1:0] ratio_bp(input longint unsigned tp,
		input longint unsigned den);
		if (den == 0 || tp == 0) begin
			return '0;
		end
		return BP_W'((tp * BP_SCALE) / den);
	endfunction

	function automatic rec_t make_rec(input bit overall, input logic [3:0] etype,
		input longint unsigned tp, input longint unsigned fp,
		input longint unsigned fn, input bit last);
		rec_t r;
		longint unsigned sum;
		sum = tp + fp;
		if (sum > CNT_MAX) begin
			sum = CNT_MAX;
		end
		r.is_overall     = overall;
		r.ent_type       = etype;
		r.true_positives = (tp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tp[31:0];
		r.guessed        = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		r.precision_bp   = ratio_bp(tp, tp + fp);
		r.recall_bp      = ratio_bp(tp, tp + fn);
		r.last_record    = last;
		return r;
	endfunction

	// A gold and a guess chunk closing together and still in agreement make
	// one true positive; anything else is scored separately on each side.
	function automatic void close_chunks(input bit gclose, input bit qclose);
		if (gclose && qclose && chunks_agree) begin
			tp_by_type[gold_open_type] = sat_inc(tp_by_type[gold_open_type]);
			tp_total = sat_inc(tp_total);
		end else begin
			if (gclose) begin
				fn_by_type[gold_open_type] = sat_inc(fn_by_type[gold_open_type]);
				fn_total = sat_inc(fn_total);
			end
			if (qclose) begin
				fp_by_type[guess_open_type] = sat_inc(fp_by_type[guess_open_type]);
				fp_total = sat_inc(fp_total);
			end
		end
		if (gclose || qclose) begin
			chunks_agree = 1'b0;
		end
		if (gclose) begin
			gold_open = 1'b0;
		end
		if (qclose) begin
			guess_open = 1'b0;
		end
	endfunction

	function automatic void score_token(input tok_t t);
		bit gcont, qcont, gstart, qstart;
		gcont = gold_open && t.gold_kind == KIND_I && t.gold_type == gold_open_type;
		qcont = guess_open && t.guess_kind == KIND_I && t.guess_type == guess_open_type;
		close_chunks(gold_open && !gcont, guess_open && !qcont);
		gstart = !gcont && t.gold_kind == KIND_B;
		qstart = !qcont && t.guess_kind != KIND_O;
		if (gstart) begin
			gold_open = 1'b1;
			gold_open_type = t.gold_type;
		end
		if (qstart) begin
			guess_open = 1'b1;
			guess_open_type = t.guess_type;
		end
		if (gstart && qstart) begin
			chunks_agree = (t.gold_type == t.guess_type);
		end else if (gstart || qstart) begin
			chunks_agree = 1'b0;
		end
		if (t.sentence_end || t.stream_end) begin
			close_chunks(gold_open, guess_open);
			chunks_agree = 1'b0;
		end
		if (t.stream_end) begin
			for (int k = 0; k < NUM_TYPES; k++) begin
				if (tp_by_type[k] != 0) begin
					expected_recs.insert(expected_recs.size(), make_rec(1'b0, 4'(k),
						tp_by_type[k], fp_by_type[k], fn_by_type[k], 1'b0));
				end
			end
			expected_recs.insert(expected_recs.size(), make_rec(1'b1, 4'd0, tp_total,
				fp_total, fn_total, 1'b1));
			tp_by_type = '{default: 0};
			fp_by_type = '{default: 0};
			fn_by_type = '{default: 0};
			tp_total = 0;
			fp_total = 0;
			fn_total = 0;
		end
	endfunction

	function automatic int pick_wait();
		if (no_gaps || $urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(1, MAX_WAIT);
	endfunction

	function automatic logic [3:0] pick_type();
		return $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
	endfunction

	function automatic tok_t tok_of(input kind_t gk, input logic [3:0] gt,
		input kind_t qk, input logic [3:0] qt, input bit se, input bit strm);
		tok_t t;
		t.gold_kind    = gk;
		t.gold_type    = gt;
		t.guess_kind   = qk;
		t.guess_type   = qt;
		t.sentence_end = se;
		t.stream_end   = strm;
		return t;
	endfunction

	// Sends one token beat and scores it once the block has taken it.
	task automatic send_tok(input tok_t t);
		int gap;
		gap = pick_wait();
		@(negedge clk);
		if (gap > 0) begin
			tok_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tok_valid <= 1'b1;
		tok <= t;
		do @(posedge clk); while (tok_stall !== 1'b0);
		score_token(t);
		tokens_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		tok_valid <= 1'b0;
		while (expected_recs.size() != 0) @(posedge clk);
	endtask

	// Report record receiver and checker.
	initial begin
		int   n;
		rec_t got, want;
		@(posedge arst_n);
		forever begin
			n = pick_wait();
			@(negedge clk);
			if (n > 0) begin
				rpt_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			rpt_stall <= 1'b0;
			do @(posedge clk); while (rpt_valid !== 1'b1);
			got = rpt;
			records_seen++;
			if (got.last_record === 1'b1) begin
				reports_seen++;
			end
			if (expected_recs.size() == 0) begin
				$error("unexpected report record: %p", got);
				mismatches++;
			end else begin
				want = expected_recs.pop_front();
				if (got !== want) begin
					mismatches++;
				end
				if (got.is_overall !== want.is_overall) begin
					$error("is_overall: expected %0d, got %0d", want.is_overall,
						got.is_overall);
				end
				if (got.ent_type !== want.ent_type) begin
					$error("ent_type: expected %0d, got %0d", want.ent_type,
						got.ent_type);
				end
				if (got.true_positives !== want.true_positives) begin
					$error("true_positives: expected %0d, got %0d",
						want.true_positives, got.true_positives);
				end
				if (got.guessed !== want.guessed) begin
					$error("guessed: expected %0d, got %0d", want.guessed, got.guessed);
				end
				if (got.precision_bp !== want.precision_bp) begin
					$error("precision_bp: expected %0d, got %0d", want.precision_bp,
						got.precision_bp);
				end
				if (got.recall_bp !== want.recall_bp) begin
					$error("recall_bp: expected %0d, got %0d", want.recall_bp,
						got.recall_bp);
				end
				if (got.last_record !== want.last_record) begin
					$error("last_record: expected %0d, got %0d", want.last_record,
						got.last_record);
				end
			end
		end
	end

	// A report right after reset has nothing counted, so the overall record has only zero counts and ratios.
	task automatic test_empty_report();
		send_tok(tok_of(KIND_O, 4'd0, KIND_O, 4'd0, 1'b0, 1'b0));
		send_tok(tok_of(KIND_O, 4'd0, KIND_O, 4'd0, 1'b1, 1'b1));
	endtask

	task automatic test_chunk_rules();
		// Matched two-token chunk of the highest type.
		send_tok(tok_of(KIND_B, 4'd15, KIND_B, 4'd15, 1'b0, 1'b0));
		send_tok(tok_of(KIND_I, 4'd15, KIND_I, 4'd15, 1'b0, 1'b0));
		send_tok(tok_of(KIND_O, 4'd0, KIND_O, 4'd0, 1'b1, 1'b0));
		// A guess I of another type closes the guess chunk and opens a new one.
		send_tok(tok_of(KIND_B, 4'd0, KIND_B, 4'd0, 1'b0, 1'b0));
		send_tok(tok_of(KIND_I, 4'd0, KIND_I, 4'd1, 1'b0, 1'b0));
		send_tok(tok_of(KIND_O, 4'd0, KIND_O, 4'd0, 1'b0, 1'b0));
		// A gold I outside a chunk is ignored; a guess I there opens a chunk.
		send_tok(tok_of(KIND_I, 4'd3, KIND_I, 4'd3, 1'b0, 1'b0));
		send_tok(tok_of(KIND_O, 4'd0, KIND_O, 4'd0, 1'b1, 1'b0));
		// Other letters open only guess chunks and never continue one.
		send_tok(tok_of(KIND_OTHER, 4'd5, KIND_OTHER, 4'd5, 1'b0, 1'b0));
		send_tok(tok_of(KIND_OTHER, 4'd5, KIND_I, 4'd5, 1'b0, 1'b0));
		send_tok(tok_of(KIND_B, 4'd5, KIND_B, 4'd5, 1'b1, 1'b0));
		// Same start, different end.
		send_tok(tok_of(KIND_B, 4'd2, KIND_B, 4'd2, 1'b0, 1'b0));
		send_tok(tok_of(KIND_I, 4'd2, KIND_O, 4'd0, 1'b0, 1'b0));
		send_tok(tok_of(KIND_O, 4'd0, KIND_O, 4'd0, 1'b0, 1'b0));
		// Gold B against a guess with another letter but the same type still matches.
		send_tok(tok_of(KIND_B, 4'd9, KIND_OTHER, 4'd9, 1'b1, 1'b0));
		// Back-to-back B tags, then a stream end on a token without a sentence end.
		send_tok(tok_of(KIND_B, 4'd7, KIND_B, 4'd7, 1'b0, 1'b0));
		send_tok(tok_of(KIND_B, 4'd7, KIND_B, 4'd7, 1'b0, 1'b0));
		send_tok(tok_of(KIND_I, 4'd7, KIND_I, 4'd7, 1'b0, 1'b1));
	endtask

	// Every type gets a true positive, so the report is as long as it can be.
	task automatic test_all_types();
		for (int k = 0; k < NUM_TYPES; k++) begin
			if (k % 3 == 0) begin
				send_tok(tok_of(KIND_O, 4'd0, KIND_B, 4'(k), 1'b1, 1'b0));
			end
			if (k % 4 == 1) begin
				send_tok(tok_of(KIND_B, 4'(k), KIND_O, 4'd0, 1'b1, 1'b0));
			end
			send_tok(tok_of(KIND_B, 4'(k), KIND_B, 4'(k), 1'b1, k == NUM_TYPES - 1));
		end
	endtask

	// Mostly well-formed gold tagging with a guess that usually follows it,
	// mixed with fully random tokens.
	task automatic test_random_tagging(input int count, input bit back_to_back);
		tok_t        t;
		bit          in_chunk;
		logic [3:0]  open_type;
		logic [31:0] raw;
		in_chunk = 1'b0;
		open_type = '0;
		no_gaps = back_to_back;
		for (int i = 0; i < count; i++) begin
			raw = $urandom;
			t = raw[$bits(tok_t)-1:0];
			if ($urandom_range(0, 9) < 7) begin
				if (in_chunk && $urandom_range(0, 2) != 0) begin
					t.gold_kind = KIND_I;
					t.gold_type = open_type;
				end else if ($urandom_range(0, 2) == 0) begin
					t.gold_kind = KIND_O;
					in_chunk = 1'b0;
				end else begin
					open_type = pick_type();
					t.gold_kind = KIND_B;
					t.gold_type = open_type;
					in_chunk = 1'b1;
				end
				if ($urandom_range(0, 3) != 0) begin
					t.guess_kind = t.gold_kind;
					t.guess_type = t.gold_type;
				end
			end else begin
				in_chunk = 1'b0;
			end
			t.sentence_end = ($urandom_range(0, 5) == 0);
			t.stream_end = (i == count - 1) || ($urandom_range(0, 24) == 0);
			if (t.sentence_end || t.stream_end) begin
				in_chunk = 1'b0;
			end
			send_tok(t);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_report();
		test_chunk_rules();
		wait_drained();
		test_all_types();
		test_random_tagging(30, 1'b0);
		wait_drained();
		test_random_tagging(20, 1'b1);
		test_random_tagging(15, 1'b0);
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Sent %0d tokens; checked %0d report records over %0d reports.",
			tokens_sent, records_seen, reports_seen);
		$display("Stimulus: chunk rules, a full per-type report, random tagging.");
		if (mismatches == 0) begin
			$display("bio_chunk_precision_recall_tb: PASS");
		end else begin
			$display("bio_chunk_precision_recall_tb: FAIL");
		end
		$finish;
	end

endmodule
